// File: src/tgarle_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// tgarle_pkg
// shared types and constants of the tga truecolor rle decoder
// ============================================================================
package tgarle_pkg;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // header layout (byte offsets)
    localparam logic [4:0] HDR_ID_LENGTH  = 5'd0;
    localparam logic [4:0] HDR_CMAP_TYPE  = 5'd1;
    localparam logic [4:0] HDR_IMAGE_TYPE = 5'd2;
    localparam logic [4:0] HDR_WIDTH_LO   = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI   = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_LO  = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_HI  = 5'd15;
    localparam logic [4:0] HDR_DEPTH      = 5'd16;
    localparam logic [4:0] HDR_LAST       = 5'd17;

    localparam logic [7:0] IMAGE_TYPE_RAW = 8'd2;
    localparam logic [7:0] IMAGE_TYPE_RLE = 8'd10;
    localparam logic [7:0] DEPTH_24       = 8'd24;
    localparam logic [7:0] DEPTH_32       = 8'd32;
    localparam logic [7:0] OPAQUE_ALPHA   = 8'd255;
    localparam logic [7:0] PACKET_LEN_MASK = 8'h7F;

    typedef enum logic [1:0] {
        KIND_RUN        = 2'd0,
        KIND_BAD_TYPE   = 2'd1,
        KIND_BAD_FORMAT = 2'd2,
        KIND_EMPTY      = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_HEADER = 3'd1,
        PH_IDSKIP = 3'd2,
        PH_PACKET = 3'd3,
        PH_PIXEL  = 3'd4
    } t_phase;

    // one classified result waiting for placement
    typedef struct packed {
        t_kind       kind;
        logic        first;   // first pixel word of the image
        logic        last;
        logic [7:0]  count;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [15:0] width;
        logic [15:0] height;
    } t_job;

endpackage

// File: src/tgarle_front.sv
`timescale 1ns / 1ps
// ============================================================================
// tgarle_front
// header parser, packet decoder and pixel assembler; while i_accept is high, one byte per cycle
// ============================================================================
module tgarle_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_first_byte,
    output logic              o_push,
    output tgarle_pkg::t_job  o_job
);

    tgarle_pkg::t_phase r_phase, n_phase;
    logic [4:0]  r_hidx, n_hidx;
    logic [7:0]  r_id_skip, n_id_skip;
    logic        r_is_rle, n_is_rle;
    logic        r_four, n_four;
    logic [15:0] r_cols, n_cols;
    logic [15:0] r_rows, n_rows;
    logic        r_bad_cmap, n_bad_cmap;
    logic        r_bad_type, n_bad_type;
    logic        r_bad_depth, n_bad_depth;
    logic [31:0] r_pix_left, n_pix_left;
    logic [7:0]  r_pkt_left, n_pkt_left;
    logic        r_pkt_run, n_pkt_run;
    logic [23:0] r_color, n_color;
    logic [1:0]  r_bip, n_bip;
    logic        r_first_pix, n_first_pix;

    tgarle_pkg::t_phase eff_phase;
    logic [4:0]  eff_hidx;
    logic        eff_cmap, eff_type, eff_depth;
    logic [23:0] color_new;
    logic        pixel_done;
    logic [7:0]  raw_count;
    logic        img_done;
    logic [31:0] area;

    assign area = r_cols * r_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= tgarle_pkg::PH_IDLE;
            r_hidx      <= '0;
            r_id_skip   <= '0;
            r_is_rle    <= 1'b0;
            r_four      <= 1'b0;
            r_bad_cmap  <= 1'b0;
            r_bad_type  <= 1'b0;
            r_bad_depth <= 1'b0;
            r_pix_left  <= '0;
            r_pkt_left  <= '0;
            r_pkt_run   <= 1'b0;
            r_color     <= '0;
            r_bip       <= '0;
            r_first_pix <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_hidx      <= n_hidx;
            r_id_skip   <= n_id_skip;
            r_is_rle    <= n_is_rle;
            r_four      <= n_four;
            r_bad_cmap  <= n_bad_cmap;
            r_bad_type  <= n_bad_type;
            r_bad_depth <= n_bad_depth;
            r_pix_left  <= n_pix_left;
            r_pkt_left  <= n_pkt_left;
            r_pkt_run   <= n_pkt_run;
            r_color     <= n_color;
            r_bip       <= n_bip;
            r_first_pix <= n_first_pix;
        end
    end

    // header size fields are payload
    always_ff @(posedge i_clk) begin
        r_cols <= n_cols;
        r_rows <= n_rows;
    end

    always_comb begin
        n_phase     = r_phase;
        n_hidx      = r_hidx;
        n_id_skip   = r_id_skip;
        n_is_rle    = r_is_rle;
        n_four      = r_four;
        n_cols      = r_cols;
        n_rows      = r_rows;
        n_bad_cmap  = r_bad_cmap;
        n_bad_type  = r_bad_type;
        n_bad_depth = r_bad_depth;
        n_pix_left  = r_pix_left;
        n_pkt_left  = r_pkt_left;
        n_pkt_run   = r_pkt_run;
        n_color     = r_color;
        n_bip       = r_bip;
        n_first_pix = r_first_pix;

        o_push       = 1'b0;
        o_job        = '0;
        o_job.kind   = tgarle_pkg::KIND_RUN;
        o_job.width  = r_cols;
        o_job.height = r_rows;

        // a first byte restarts header parsing
        eff_phase = i_first_byte ? tgarle_pkg::PH_HEADER : r_phase;
        eff_hidx  = i_first_byte ? 5'd0 : r_hidx;
        eff_cmap  = i_first_byte ? 1'b0 : r_bad_cmap;
        eff_type  = i_first_byte ? 1'b0 : r_bad_type;
        eff_depth = i_first_byte ? 1'b0 : r_bad_depth;

        color_new = r_color;
        case (r_bip)
            2'd0:    color_new[7:0]   = i_data_byte;
            2'd1:    color_new[15:8]  = i_data_byte;
            2'd2:    color_new[23:16] = i_data_byte;
            default: color_new = r_color;
        endcase
        pixel_done = r_four ? (r_bip == 2'd3) : (r_bip == 2'd2);
        raw_count  = (r_is_rle && r_pkt_run) ? r_pkt_left : 8'd1;
        img_done   = ({24'd0, raw_count} >= r_pix_left);

        if (i_accept) begin
            n_hidx      = eff_hidx;
            n_bad_cmap  = eff_cmap;
            n_bad_type  = eff_type;
            n_bad_depth = eff_depth;
            if (i_first_byte) begin
                n_phase     = tgarle_pkg::PH_HEADER;
                n_first_pix = 1'b0;
            end
            unique case (eff_phase)
                tgarle_pkg::PH_HEADER: begin
                    unique case (eff_hidx)
                        tgarle_pkg::HDR_ID_LENGTH:  n_id_skip = i_data_byte;
                        tgarle_pkg::HDR_CMAP_TYPE:
                            if (i_data_byte != 8'd0) n_bad_cmap = 1'b1;
                        tgarle_pkg::HDR_IMAGE_TYPE: begin
                            n_is_rle = (i_data_byte == tgarle_pkg::IMAGE_TYPE_RLE);
                            if (i_data_byte != tgarle_pkg::IMAGE_TYPE_RAW &&
                                i_data_byte != tgarle_pkg::IMAGE_TYPE_RLE)
                                n_bad_type = 1'b1;
                        end
                        tgarle_pkg::HDR_WIDTH_LO:  n_cols[7:0]  = i_data_byte;
                        tgarle_pkg::HDR_WIDTH_HI:  n_cols[15:8] = i_data_byte;
                        tgarle_pkg::HDR_HEIGHT_LO: n_rows[7:0]  = i_data_byte;
                        tgarle_pkg::HDR_HEIGHT_HI: n_rows[15:8] = i_data_byte;
                        tgarle_pkg::HDR_DEPTH: begin
                            n_four = (i_data_byte == tgarle_pkg::DEPTH_32);
                            if (i_data_byte != tgarle_pkg::DEPTH_24 &&
                                i_data_byte != tgarle_pkg::DEPTH_32)
                                n_bad_depth = 1'b1;
                        end
                        default: ;
                    endcase
                    if (eff_hidx != tgarle_pkg::HDR_LAST) begin
                        n_hidx = eff_hidx + 5'd1;
                    end else begin
                        n_phase    = tgarle_pkg::PH_IDLE;
                        o_job.last = 1'b1;
                        if (eff_type) begin
                            o_push     = 1'b1;
                            o_job.kind = tgarle_pkg::KIND_BAD_TYPE;
                        end else if (eff_cmap || eff_depth) begin
                            o_push     = 1'b1;
                            o_job.kind = tgarle_pkg::KIND_BAD_FORMAT;
                        end else if (r_cols == 16'd0 || r_rows == 16'd0) begin
                            o_push     = 1'b1;
                            o_job.kind = tgarle_pkg::KIND_EMPTY;
                        end else begin
                            n_pix_left  = area;
                            n_first_pix = 1'b1;
                            n_bip       = 2'd0;
                            n_color     = '0;
                            n_pkt_left  = '0;
                            n_pkt_run   = 1'b0;
                            if (r_id_skip != 8'd0)
                                n_phase = tgarle_pkg::PH_IDSKIP;
                            else if (r_is_rle)
                                n_phase = tgarle_pkg::PH_PACKET;
                            else
                                n_phase = tgarle_pkg::PH_PIXEL;
                        end
                    end
                end
                tgarle_pkg::PH_IDSKIP: begin
                    n_id_skip = r_id_skip - 8'd1;
                    if (r_id_skip == 8'd1)
                        n_phase = r_is_rle ? tgarle_pkg::PH_PACKET : tgarle_pkg::PH_PIXEL;
                end
                tgarle_pkg::PH_PACKET: begin
                    n_pkt_left = (i_data_byte & tgarle_pkg::PACKET_LEN_MASK) + 8'd1;
                    n_pkt_run  = i_data_byte[7];
                    n_bip      = 2'd0;
                    n_color    = '0;
                    n_phase    = tgarle_pkg::PH_PIXEL;
                end
                tgarle_pkg::PH_PIXEL: begin
                    if (!pixel_done) begin
                        n_bip   = r_bip + 2'd1;
                        n_color = color_new;
                    end else begin
                        n_bip   = 2'd0;
                        n_color = '0;
                        o_push      = 1'b1;
                        o_job.first = r_first_pix;
                        n_first_pix = 1'b0;
                        o_job.blue  = color_new[7:0];
                        o_job.green = color_new[15:8];
                        o_job.red   = color_new[23:16];
                        o_job.alpha = r_four ? i_data_byte : tgarle_pkg::OPAQUE_ALPHA;
                        o_job.last  = img_done;
                        o_job.count = img_done ? r_pix_left[7:0] : raw_count;
                        if (img_done) begin
                            n_pix_left = '0;
                            n_phase    = tgarle_pkg::PH_IDLE;
                        end else begin
                            n_pix_left = r_pix_left - {24'd0, raw_count};
                            if (r_is_rle) begin
                                if (r_pkt_run || r_pkt_left <= 8'd1) begin
                                    n_pkt_left = '0;
                                    n_phase    = tgarle_pkg::PH_PACKET;
                                end else begin
                                    n_pkt_left = r_pkt_left - 8'd1;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// File: src/tgarle_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// tgarle_queue
// small first-in first-out queue of classified words
// ============================================================================
module tgarle_queue #(
    parameter int DEPTH = tgarle_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tgarle_pkg::t_job  i_job,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output tgarle_pkg::t_job  o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tgarle_pkg::t_job r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push)
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            if (do_pop)
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            if (do_push && !do_pop)
                r_count <= r_count + 1'b1;
            else if (do_pop && !do_push)
                r_count <= r_count - 1'b1;
        end
    end

endmodule

// File: src/tgarle_back.sv
`timescale 1ns / 1ps
// ============================================================================
// tgarle_back
// places runs on the image grid and holds the result register
// ============================================================================
module tgarle_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  tgarle_pkg::t_job  i_head,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_kind,
    output logic [15:0]       o_start_row,
    output logic [15:0]       o_start_column,
    output logic [7:0]        o_run_count,
    output logic [7:0]        o_red,
    output logic [7:0]        o_green,
    output logic [7:0]        o_blue,
    output logic [7:0]        o_alpha,
    output logic [15:0]       o_image_width,
    output logic [15:0]       o_image_height,
    output logic              o_last
);

    logic        r_valid;
    logic        r_busy, n_busy;
    logic [15:0] r_row, n_row;
    logic [15:0] r_col, n_col;
    logic [16:0] r_acc, n_acc;
    logic [15:0] r_cols, n_cols;

    logic        take;
    logic        is_run;
    logic [15:0] base_row, base_col;
    logic [16:0] sum, over, step;

    assign o_pop  = take;
    assign take   = !i_empty && !r_busy && (!r_valid || i_out_ready);
    assign is_run = (i_head.kind == tgarle_pkg::KIND_RUN);

    assign base_row = i_head.first ? i_head.height - 16'd1 : r_row;
    assign base_col = i_head.first ? 16'd0 : r_col;
    assign sum      = {1'b0, base_col} + {9'd0, i_head.count};
    assign over     = sum - {1'b0, i_head.width};
    assign step     = r_acc - {1'b0, r_cols};

    always_comb begin
        n_busy = r_busy;
        n_row  = r_row;
        n_col  = r_col;
        n_acc  = r_acc;
        n_cols = r_cols;
        if (r_busy) begin
            // one more row end crossed per cycle
            n_row = r_row - 16'd1;
            if (step < {1'b0, r_cols}) begin
                n_col  = step[15:0];
                n_busy = 1'b0;
            end else begin
                n_acc = step;
            end
        end else if (take && is_run && !i_head.last) begin
            n_cols = i_head.width;
            if (sum < {1'b0, i_head.width}) begin
                n_row = base_row;
                n_col = sum[15:0];
            end else begin
                n_row = base_row - 16'd1;
                if (over < {1'b0, i_head.width}) begin
                    n_col = over[15:0];
                end else begin
                    n_acc  = over;
                    n_busy = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_busy  <= 1'b0;
        end else begin
            r_busy <= n_busy;
            if (take)
                r_valid <= 1'b1;
            else if (i_out_ready)
                r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row  <= n_row;
        r_col  <= n_col;
        r_acc  <= n_acc;
        r_cols <= n_cols;
        if (take) begin
            o_kind         <= i_head.kind;
            o_start_row    <= is_run ? base_row : 16'd0;
            o_start_column <= is_run ? base_col : 16'd0;
            o_run_count    <= i_head.count;
            o_red          <= i_head.red;
            o_green        <= i_head.green;
            o_blue         <= i_head.blue;
            o_alpha        <= i_head.alpha;
            o_image_width  <= i_head.width;
            o_image_height <= i_head.height;
            o_last         <= i_head.last;
        end
    end

    assign o_out_valid = r_valid;

endmodule

// File: src/tga_rle_image_decoder.sv
`timescale 1ns / 1ps
// ============================================================================
// tga_rle_image_decoder
// truecolor tga decoder (raw and rle, 24 and 32 bit) fed one byte per word
// ============================================================================
// The block takes a tga file one byte per input word, with i_first_byte high
// on byte 0 of each file, and returns one result word per raw pixel or per
// rle run packet: color as rgba, the destination row and column of the first
// pixel (bottom row first, top row is 0) and a count that is clipped at the
// image end. Header problems (image type other than raw or rle, a colormap,
// depth other than 24 or 32) and empty images are reported as one word with
// o_last high once the 18 header bytes are in; the word that fills the last
// pixel also carries o_last. Bytes that arrive with no file open are taken
// and dropped. Input takes one byte every cycle while the queue between the
// byte parser and the placement stage has room. The placement stage emits
// one result per cycle while the output side is ready; a run that crosses
// more than one row end (images narrower than the run) holds it until every
// row end is crossed, as column wrap is a repeated subtract of the image width.
module tga_rle_image_decoder #(
    parameter int QUEUE_DEPTH = tgarle_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [15:0] o_start_row,
    output logic [15:0] o_start_column,
    output logic [7:0]  o_run_count,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic [15:0] o_image_width,
    output logic [15:0] o_image_height,
    output logic        o_last
);

    logic             accept;
    logic             push;
    logic             pop;
    logic             full;
    logic             empty;
    tgarle_pkg::t_job job;
    tgarle_pkg::t_job head;

    // a byte word is taken whenever the queue can hold what it may produce
    assign o_in_ready = !full;
    assign accept     = i_in_valid && !full;

    // parser: header, id skip, packet headers, pixel assembly, clipping
    tgarle_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .o_push       (push),
        .o_job        (job)
    );

    // decouples the byte side from result stalls
    tgarle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    // placement of runs on the grid plus output register
    tgarle_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_head         (head),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_start_row    (o_start_row),
        .o_start_column (o_start_column),
        .o_run_count    (o_run_count),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_alpha        (o_alpha),
        .o_image_width  (o_image_width),
        .o_image_height (o_image_height),
        .o_last         (o_last)
    );

endmodule
